@@ sv/mck_pkg.sv @@
package mck_pkg;

	localparam logic [15:0] UNIT_TICKS_RESET = 16'd400;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_MARK = 2'd1,
		PH_GAP  = 2'd2,
		PH_END  = 2'd3
	} mck_phase_t;

	typedef struct packed {
		logic       command;
		logic [7:0] character;
	} mck_cmd_t;

	typedef struct packed {
		logic led;
		logic busy_res;
		logic accepted;
	} mck_res_t;

	typedef struct packed {
		logic [3:0]  dash_marks;
		logic [2:0]  elements_left;
		mck_phase_t  phase;
		logic [2:0]  units_left;
		logic [15:0] tick_in_unit;
	} mck_state_t;

	// element count in bits 6..4, dash pattern in bits 3..0, first element in bit 0
	function automatic logic [6:0] letter_code(input logic [4:0] idx);
		logic [6:0] code;
		begin
			case (idx)
				5'd0:    code = 7'h22;
				5'd1:    code = 7'h41;
				5'd2:    code = 7'h45;
				5'd3:    code = 7'h31;
				5'd4:    code = 7'h10;
				5'd5:    code = 7'h44;
				5'd6:    code = 7'h33;
				5'd7:    code = 7'h40;
				5'd8:    code = 7'h20;
				5'd9:    code = 7'h4E;
				5'd10:   code = 7'h35;
				5'd11:   code = 7'h42;
				5'd12:   code = 7'h23;
				5'd13:   code = 7'h21;
				5'd14:   code = 7'h37;
				5'd15:   code = 7'h46;
				5'd16:   code = 7'h4B;
				5'd17:   code = 7'h32;
				5'd18:   code = 7'h30;
				5'd19:   code = 7'h11;
				5'd20:   code = 7'h34;
				5'd21:   code = 7'h48;
				5'd22:   code = 7'h36;
				5'd23:   code = 7'h49;
				5'd24:   code = 7'h4D;
				5'd25:   code = 7'h43;
				default: code = 7'h00;
			endcase
			return code;
		end
	endfunction

endpackage

@@ sv/mck_step.sv @@
module mck_step (
	input  mck_pkg::mck_state_t state,
	input  logic [15:0]         unit_ticks,
	input  mck_pkg::mck_cmd_t   item,
	output mck_pkg::mck_state_t state_next,
	output mck_pkg::mck_res_t   result
);

	logic [7:0]  ch_fold;
	logic [7:0]  ch_off;
	logic        is_letter;
	logic [6:0]  code;
	logic [16:0] tick_inc;
	logic        unit_done;
	logic [2:0]  units_dec;
	logic [2:0]  elems_dec;
	logic [3:0]  dash_shift;
	logic        led_pre;
	logic        accepted;

	// case folding and letter lookup
	assign ch_fold = ((item.character >= mck_pkg::CHAR_UPPER_A) &&
		(item.character <= mck_pkg::CHAR_UPPER_Z)) ?
		(item.character + mck_pkg::CASE_OFFSET) : item.character;
	assign is_letter = (ch_fold >= mck_pkg::CHAR_LOWER_A) &&
		(ch_fold <= mck_pkg::CHAR_LOWER_Z);
	assign ch_off = ch_fold - mck_pkg::CHAR_LOWER_A;
	assign code = mck_pkg::letter_code(ch_off[4:0]);

	// unit timing
	assign tick_inc   = {1'b0, state.tick_in_unit} + 17'd1;
	assign unit_done  = tick_inc >= {1'b0, unit_ticks};
	assign units_dec  = state.units_left - 3'd1;
	assign elems_dec  = state.elements_left - 3'd1;
	assign dash_shift = {1'b0, state.dash_marks[3:1]};
	assign led_pre    = (state.phase == mck_pkg::PH_MARK);

	// next state
	always_comb begin
		state_next = state;
		accepted   = 1'b0;
		if (item.command == mck_pkg::CMD_LOAD) begin
			if (state.phase == mck_pkg::PH_IDLE) begin
				accepted = 1'b1;
				state_next.tick_in_unit = '0;
				if (is_letter) begin
					state_next.dash_marks    = code[3:0];
					state_next.elements_left = code[6:4];
					state_next.phase         = mck_pkg::PH_MARK;
					state_next.units_left    = code[0] ? 3'd3 : 3'd1;
				end else begin
					state_next.dash_marks    = '0;
					state_next.elements_left = '0;
					state_next.phase         = mck_pkg::PH_END;
					state_next.units_left    =
						(ch_fold == mck_pkg::CHAR_UNDERSCORE) ? 3'd6 : 3'd3;
				end
			end
		end else if (state.phase != mck_pkg::PH_IDLE) begin
			if (!unit_done) begin
				state_next.tick_in_unit = tick_inc[15:0];
			end else begin
				state_next.tick_in_unit = '0;
				state_next.units_left   = units_dec;
				if (units_dec == 3'd0) begin
					case (state.phase)
						mck_pkg::PH_MARK: begin
							state_next.elements_left = elems_dec;
							if (elems_dec != 3'd0) begin
								state_next.phase      = mck_pkg::PH_GAP;
								state_next.units_left = 3'd1;
							end else begin
								state_next.phase      = mck_pkg::PH_END;
								state_next.units_left = 3'd3;
							end
						end
						mck_pkg::PH_GAP: begin
							state_next.dash_marks = dash_shift;
							state_next.phase      = mck_pkg::PH_MARK;
							state_next.units_left = dash_shift[0] ? 3'd3 : 3'd1;
						end
						default: begin
							state_next.phase         = mck_pkg::PH_IDLE;
							state_next.units_left    = '0;
							state_next.dash_marks    = '0;
							state_next.elements_left = '0;
						end
					endcase
				end
			end
		end
	end

	// result: a tick shows the level during the tick, a load the level after it
	always_comb begin
		result.accepted = accepted;
		result.busy_res = (state_next.phase != mck_pkg::PH_IDLE);
		if (item.command == mck_pkg::CMD_LOAD) begin
			result.led = (state_next.phase == mck_pkg::PH_MARK);
		end else begin
			result.led = led_pre;
		end
	end

endmodule

@@ sv/morse_code_keyer.sv @@
// Morse code keyer: keys ASCII characters onto an LED one at a time.
// Command channel (cmd_valid/cmd_stall/cmd) carries either a tick, which
// advances time by one tick, or a load of one character, which is taken only
// while the keyer is idle. Every command transaction yields exactly one
// result transaction on res_valid/res_stall/res with the LED level, busy and
// whether a load was taken.
// The unit length in ticks is set through cfg_wr_en/cfg_wr_data; write it
// only while no command is in flight.
// Path: a taken command waits in the input register, then its result is
// written into the result register, from which it is taken; a waiting
// result under res_stall holds the command in the input register.
// Throughput: one command per cycle while the result register is free or
// drained; the step logic between the registers updates the keyer state.
// Reset clears the keyer to idle, empties both registers and sets the unit
// length to 400 ticks. When res_stall holds a waiting result, one more
// command is still taken into the input register; after that cmd_stall
// rises until the result is taken.
module morse_code_keyer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  mck_pkg::mck_cmd_t cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output mck_pkg::mck_res_t res,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data
);

	logic                valid_s1;
	mck_pkg::mck_cmd_t   item_s1;
	mck_pkg::mck_state_t state_q;
	mck_pkg::mck_state_t state_next;
	mck_pkg::mck_res_t   result;
	logic [15:0]         unit_ticks_q;
	logic                advance;

	// the step fires when the result register is free or being drained
	assign advance   = valid_s1 && (!res_valid || !res_stall);
	assign cmd_stall = valid_s1 && !advance;

	// unit length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= mck_pkg::UNIT_TICKS_RESET;
		end else if (cfg_wr_en) begin
			unit_ticks_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	mck_step u_step (
		.state      (state_q),
		.unit_ticks (unit_ticks_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	// keyer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.dash_marks    <= '0;
			state_q.elements_left <= '0;
			state_q.phase         <= mck_pkg::PH_IDLE;
			state_q.units_left    <= '0;
			state_q.tick_in_unit  <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (!res_valid || !res_stall) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res <= result;
		end
	end

	// a taken load always starts a sequence
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.accepted |-> res.busy_res)
		else $error("accepted load without busy");

	// the led is only lit inside a sequence
	a_led_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.led |-> res.busy_res)
		else $error("led on while idle");

	// idle state keeps its counters cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == mck_pkg::PH_IDLE |->
		state_q.units_left == 3'd0 && state_q.elements_left == 3'd0 &&
		state_q.dash_marks == 4'd0)
		else $error("idle state not cleared");

	// a mark always has an element and time left
	a_mark_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == mck_pkg::PH_MARK |->
		state_q.units_left != 3'd0 && state_q.elements_left != 3'd0)
		else $error("mark with nothing left");

	// a step that fires always leaves a valid result
	a_advance_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid)
		else $error("step fired without result");

endmodule

@@ test/morse_code_keyer_tb.sv @@
module morse_code_keyer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 800;
	localparam int IDLE_PCT     = 26;
	localparam int CALM_FROM    = 900;
	localparam int CALM_TO      = 1250;
	localparam int HOLD_AT      = 600;
	localparam int HOLD_CYCLES  = 80;
	localparam int FIRST_TICKS  = 420;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	mck_pkg::mck_cmd_t  cmd = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	mck_pkg::mck_res_t  res;
	logic               cfg_wr_en = 1'b0;
	logic [15:0]        cfg_wr_data = '0;

	morse_code_keyer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// pending commands, expected keying results
	mck_pkg::mck_cmd_t    cmd_backlog[$];
	mck_pkg::mck_res_t    keying_q[$];

	// keyer state as seen by the stimulus planner and by the checker
	mck_pkg::mck_state_t  plan_state = '0;
	logic [15:0]          plan_unit = mck_pkg::UNIT_TICKS_RESET;
	mck_pkg::mck_state_t  live_state = '0;
	logic [15:0]          live_unit = mck_pkg::UNIT_TICKS_RESET;
	mck_pkg::mck_state_t  live_next;
	mck_pkg::mck_res_t    want;

	int          planned_items = 0;
	int          queued_total = 0;
	int          cmds_taken = 0;
	int          results_seen = 0;
	int          err_count = 0;
	int          ticks_seen = 0;
	int          loads_taken = 0;
	int          loads_refused = 0;
	logic        cmd_taken = 1'b0;
	logic        hold_on = 1'b0;

	always #5 clk = ~clk;

	// dot/dash spelling of each letter, first element leftmost
	function automatic string morse_pattern(input int idx);
		case (idx)
			0:  return ".-";
			1:  return "-...";
			2:  return "-.-.";
			3:  return "-..";
			4:  return ".";
			5:  return "..-.";
			6:  return "--.";
			7:  return "....";
			8:  return "..";
			9:  return ".---";
			10: return "-.-";
			11: return ".-..";
			12: return "--";
			13: return "-.";
			14: return "---";
			15: return ".--.";
			16: return "--.-";
			17: return ".-.";
			18: return "...";
			19: return "-";
			20: return "..-";
			21: return "...-";
			22: return ".--";
			23: return "-..-";
			24: return "-.--";
			25: return "--..";
			default: return "";
		endcase
	endfunction

	// one keyer step: returns the result and the state after the transaction
	function automatic mck_pkg::mck_res_t predict_keying(input mck_pkg::mck_state_t cur,
			input mck_pkg::mck_cmd_t c, input logic [15:0] unit,
			output mck_pkg::mck_state_t nxt);
		mck_pkg::mck_state_t s;
		mck_pkg::mck_res_t   r;
		logic [7:0] ch;
		logic [3:0] dashes;
		logic [16:0] t;
		string      pat;
		s = cur;
		r = '0;
		if (c.command == mck_pkg::CMD_LOAD) begin
			if (s.phase == mck_pkg::PH_IDLE) begin
				s.tick_in_unit = '0;
				ch = c.character;
				if (ch >= mck_pkg::CHAR_UPPER_A && ch <= mck_pkg::CHAR_UPPER_Z)
					ch = ch + mck_pkg::CASE_OFFSET;
				if (ch >= mck_pkg::CHAR_LOWER_A && ch <= mck_pkg::CHAR_LOWER_Z) begin
					pat = morse_pattern(ch - mck_pkg::CHAR_LOWER_A);
					dashes = '0;
					for (int i = 0; i < pat.len(); i++)
						if (pat[i] == "-")
							dashes[i] = 1'b1;
					s.dash_marks = dashes;
					s.elements_left = 3'(pat.len());
					s.phase = mck_pkg::PH_MARK;
					s.units_left = dashes[0] ? 3'd3 : 3'd1;
				end else begin
					// underscore is a long pause, anything else a letter pause
					s.dash_marks = '0;
					s.elements_left = '0;
					s.phase = mck_pkg::PH_END;
					s.units_left = (ch == mck_pkg::CHAR_UNDERSCORE) ? 3'd6 : 3'd3;
				end
				r.accepted = 1'b1;
			end
			r.led = (s.phase == mck_pkg::PH_MARK);
		end else begin
			r.led = (s.phase == mck_pkg::PH_MARK);
			if (s.phase != mck_pkg::PH_IDLE) begin
				t = {1'b0, s.tick_in_unit} + 17'd1;
				// zero unit length ends every unit on its first tick
				if (t >= {1'b0, unit}) begin
					s.tick_in_unit = '0;
					s.units_left = s.units_left - 3'd1;
					if (s.units_left == 3'd0) begin
						case (s.phase)
							mck_pkg::PH_MARK: begin
								s.elements_left = s.elements_left - 3'd1;
								if (s.elements_left != 3'd0) begin
									s.phase = mck_pkg::PH_GAP;
									s.units_left = 3'd1;
								end else begin
									s.phase = mck_pkg::PH_END;
									s.units_left = 3'd3;
								end
							end
							mck_pkg::PH_GAP: begin
								s.dash_marks = s.dash_marks >> 1;
								s.phase = mck_pkg::PH_MARK;
								s.units_left = s.dash_marks[0] ? 3'd3 : 3'd1;
							end
							default: begin
								s = '0;
								s.phase = mck_pkg::PH_IDLE;
							end
						endcase
					end
				end else begin
					s.tick_in_unit = t[15:0];
				end
			end
		end
		r.busy_res = (s.phase != mck_pkg::PH_IDLE);
		nxt = s;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		err_count++;
	endtask

	// plan one transaction and queue it for the driver
	task automatic queue_item(input logic command, input logic [7:0] ch);
		mck_pkg::mck_cmd_t   c;
		mck_pkg::mck_state_t nxt;
		mck_pkg::mck_res_t   r;
		c.command = command;
		c.character = ch;
		r = predict_keying(plan_state, c, plan_unit, nxt);
		plan_state = nxt;
		if (!(command == mck_pkg::CMD_LOAD && !r.accepted))
			planned_items++;
		queued_total++;
		cmd_backlog.push_back(c);
	endtask

	// tick until the keyer is idle again, with refused loads mixed in
	task automatic tick_out(input int noise_pct);
		while (plan_state.phase != mck_pkg::PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct)
				queue_item(mck_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
			else
				queue_item(mck_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	// load a character and tick until it is keyed out
	task automatic key_char(input logic [7:0] ch, input int noise_pct);
		queue_item(mck_pkg::CMD_LOAD, ch);
		tick_out(noise_pct);
	endtask

	task automatic wait_drained();
		while (results_seen != queued_total)
			@(negedge clk);
	endtask

	task automatic set_unit(input logic [15:0] v);
		wait_drained();
		repeat (3) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		plan_unit = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return mck_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
		else if (roll < 75)
			return mck_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
		else if (roll < 83)
			return mck_pkg::CHAR_UNDERSCORE;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_unit();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1, 2:    return 16'd1;
			3:       return 16'd2;
			4:       return 16'd3;
			default: return 16'($urandom_range(4, 9));
		endcase
	endfunction

	// reset
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// stimulus
	initial begin
		int rand_start;
		int next_switch;
		int roll;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// reset unit length: tick while idle, then an uppercase letter past its first unit
		queue_item(mck_pkg::CMD_TICK, 8'h00);
		queue_item(mck_pkg::CMD_LOAD, mck_pkg::CHAR_UPPER_A + 8'd4);
		repeat (FIRST_TICKS) begin
			if ($urandom_range(0, 99) < 3)
				queue_item(mck_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
			else
				queue_item(mck_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
		end

		// unit shortened in the middle of a unit, then one-tick units
		set_unit(16'd1);
		tick_out(0);
		queue_item(mck_pkg::CMD_TICK, 8'hFF);
		key_char(mck_pkg::CHAR_UPPER_A, 0);
		key_char(mck_pkg::CHAR_UPPER_Z, 0);
		key_char(mck_pkg::CHAR_LOWER_A, 0);
		key_char(mck_pkg::CHAR_LOWER_Z, 0);
		key_char(mck_pkg::CHAR_UNDERSCORE, 0);
		key_char(8'h00, 0);
		key_char(8'hFF, 0);
		key_char(mck_pkg::CHAR_UPPER_A - 8'd1, 0);
		key_char(mck_pkg::CHAR_UPPER_Z + 8'd1, 0);
		key_char(mck_pkg::CHAR_LOWER_A - 8'd1, 0);
		key_char(mck_pkg::CHAR_LOWER_Z + 8'd1, 0);
		key_char(8'h30, 0);
		// loads while busy are refused
		key_char(mck_pkg::CHAR_LOWER_A + 8'd9, 50);

		// zero unit length acts as one tick
		set_unit(16'd0);
		key_char(mck_pkg::CHAR_LOWER_A + 8'd16, 10);
		key_char(mck_pkg::CHAR_UNDERSCORE, 0);

		// random traffic over short unit lengths
		rand_start = planned_items;
		next_switch = rand_start;
		while (planned_items - rand_start < RANDOM_ITEMS) begin
			if (planned_items >= next_switch) begin
				set_unit(pick_unit());
				next_switch = planned_items + 250;
			end
			roll = $urandom_range(0, 99);
			if (roll < 85)
				key_char(pick_char(), 5);
			else if (roll < 93)
				queue_item(mck_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
			else
				key_char(8'($urandom_range(0, 255)), 30);
		end

		// longest unit: a dot that stays lit through the rest of the run
		set_unit(16'hFFFF);
		queue_item(mck_pkg::CMD_LOAD, mck_pkg::CHAR_LOWER_A + 8'd4);
		repeat (300) begin
			if ($urandom_range(0, 99) < 10)
				queue_item(mck_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
			else
				queue_item(mck_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (keying_q.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived", keying_q.size()));
		$display("covered %0d ticks, %0d loads keyed, %0d loads refused while busy",
			ticks_seen, loads_taken, loads_refused);
		$display("unit lengths from 0 through 65535, reset value included; %0d mismatches",
			err_count);
		if (err_count == 0)
			$display("morse_code_keyer_tb: PASS");
		else
			$display("morse_code_keyer_tb: FAIL");
		$finish;
	end

	// command driver
	always @(negedge clk) begin
		if (cmd_valid && !cmd_taken) begin
			// stalled transaction stays on the bus
		end else if (cmd_backlog.size() != 0 && (hold_on ||
				(cmds_taken >= CALM_FROM && cmds_taken < CALM_TO) ||
				$urandom_range(0, 99) >= IDLE_PCT)) begin
			cmd <= cmd_backlog.pop_front();
			cmd_valid <= 1'b1;
		end else begin
			cmd_valid <= 1'b0;
		end
	end

	// result stall
	always @(negedge clk) begin
		if (hold_on)
			res_stall <= 1'b1;
		else if (results_seen >= CALM_FROM && results_seen < CALM_TO)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(0, 99) < IDLE_PCT);
	end

	// long receiver hold-off so the keyer backs up into its input
	initial begin
		wait (results_seen >= HOLD_AT);
		@(posedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	// predict on each command transaction, check each result transaction
	always @(posedge clk) begin
		cmd_taken = arst_n && cmd_valid && !cmd_stall;
		if (arst_n && cfg_wr_en)
			live_unit = cfg_wr_data;
		if (cmd_taken) begin
			want = predict_keying(live_state, cmd, live_unit, live_next);
			live_state = live_next;
			keying_q.push_back(want);
			cmds_taken++;
			if (cmd.command == mck_pkg::CMD_TICK)
				ticks_seen++;
			else if (want.accepted)
				loads_taken++;
			else
				loads_refused++;
		end
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			results_seen++;
			if (keying_q.size() == 0) begin
				flag_mismatch("result transaction with nothing expected");
			end else begin
				want = keying_q.pop_front();
				if (res.led !== want.led)
					flag_mismatch($sformatf("result %0d led %b, want %b",
						results_seen, res.led, want.led));
				if (res.busy_res !== want.busy_res)
					flag_mismatch($sformatf("result %0d busy_res %b, want %b",
						results_seen, res.busy_res, want.busy_res));
				if (res.accepted !== want.accepted)
					flag_mismatch($sformatf("result %0d accepted %b, want %b",
						results_seen, res.accepted, want.accepted));
			end
		end
	end

	// watchdog
	initial begin
		#2000000;
		$display("timeout with %0d of %0d results seen", results_seen, queued_total);
		$display("morse_code_keyer_tb: FAIL");
		$finish;
	end

endmodule
